>>> hw/rtl/palette_blend_ztest_pixel_macros.svh
// Assertion macros for the palette blitter RTL.
// Included by files that check their own pipeline; relies on i_clk and i_rst_n in scope.
`ifndef PALETTE_BLEND_ZTEST_PIXEL_MACROS_SVH
`define PALETTE_BLEND_ZTEST_PIXEL_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define PBZ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define PBZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pbz_pkg.sv
// Shared types and constants for the palette blitter.
// No dependencies; used by palette_blend_ztest_pixel and its testbench.
package pbz_pkg;

    localparam int TableEntries = 256;
    localparam int IdxW         = $clog2(TableEntries);
    localparam int ColorW       = 16;
    localparam int DepthW       = 16;
    localparam int RemapW       = 8;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 16;

    typedef enum logic [1:0] {
        CMD_PIXEL        = 2'd0,
        CMD_LOAD_PALETTE = 2'd1,
        CMD_LOAD_REMAP   = 2'd2,
        CMD_RESERVED     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        BLEND_COPY    = 3'd0,
        BLEND_DARKEN  = 3'd1,
        BLEND_HALF    = 3'd2,
        BLEND_QUARTER = 3'd3,
        BLEND_THREEQ  = 3'd4
    } t_blend;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TRANSLATE   = 3'd0,
        REG_BLEND       = 3'd1,
        REG_TRANSPARENT = 3'd2,
        REG_DEPTH_TEST  = 3'd3,
        REG_DEPTH_WRITE = 3'd4,
        REG_DEPTH_BYTE  = 3'd5,
        REG_Z_MIN       = 3'd6,
        REG_COLOR_MASK  = 3'd7
    } t_cfg_reg;

endpackage

>>> hw/rtl/palette_blend_ztest_pixel.sv
// Palette blitter top level: remap, palette lookup, depth test and blend.
// Depends on pbz_pkg and palette_blend_ztest_pixel_macros.svh.
//
//  channel   | signals                                    | direction
//  ----------+--------------------------------------------+----------
//  request   | i_in_valid / o_in_stall, command + fields  | in
//  result    | o_out_valid / i_out_stall, result fields   | out
//  config    | i_cfg_we, i_cfg_index, i_cfg_data          | in
//
// One request per clock while the output is not stalled; its result is held in stage 3.
// Stage 1 reads the remap memory, stage 2 reads the palette memory, stage 3
// holds the blended result. Synchronous active-low reset clears valid bits and
// configuration registers; table memories hold garbage until loaded. A stall at
// the output while stage 3 is valid freezes all three stages together, so input stall follows it.
`include "palette_blend_ztest_pixel_macros.svh"

module palette_blend_ztest_pixel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [pbz_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [pbz_pkg::CfgDataW-1:0]  i_cfg_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [pbz_pkg::IdxW-1:0]      i_source_index,
    input  logic [pbz_pkg::ColorW-1:0]    i_dest_pixel,
    input  logic [pbz_pkg::DepthW-1:0]    i_depth_value,
    input  logic [15:0]                   i_table_data,
    input  logic                          i_row_end,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pbz_pkg::ColorW-1:0]    o_new_dest,
    output logic                          o_dest_written,
    output logic [pbz_pkg::DepthW-1:0]    o_new_depth,
    output logic                          o_depth_written,
    output logic                          o_row_end_out
);

    // configuration registers
    logic                          r_translate;
    logic [2:0]                    r_blend_mode;
    logic                          r_transparent;
    logic                          r_depth_test;
    logic                          r_depth_write;
    logic                          r_depth_byte;
    logic [pbz_pkg::DepthW-1:0]    r_z_min;
    logic [pbz_pkg::ColorW-1:0]    r_color_mask;

    // table memories
    logic [pbz_pkg::RemapW-1:0]    r_remap_mem   [pbz_pkg::TableEntries];
    logic [pbz_pkg::ColorW-1:0]    r_palette_mem [pbz_pkg::TableEntries];

    // pipeline control
    logic                          w_advance;
    logic                          w_accept;
    logic                          r_v1, r_v2, r_v3;

    // stage 1
    pbz_pkg::t_cmd                 r1_cmd;
    logic [pbz_pkg::IdxW-1:0]      r1_src;
    logic [pbz_pkg::ColorW-1:0]    r1_dest;
    logic [pbz_pkg::DepthW-1:0]    r1_depth;
    logic [15:0]                   r1_data;
    logic                          r1_row_end;
    logic [pbz_pkg::RemapW-1:0]    r1_remap_q;

    // stage 2
    logic [pbz_pkg::ColorW-1:0]    r2_dest;
    logic [pbz_pkg::ColorW-1:0]    r2_dpart;
    logic [pbz_pkg::DepthW-1:0]    r2_depth;
    logic                          r2_draw;
    logic                          r2_zwrite;
    logic                          r2_row_end;
    logic [pbz_pkg::ColorW-1:0]    r2_pal_q;

    // stage 3 / output
    logic [pbz_pkg::ColorW-1:0]    r3_new_dest;
    logic                          r3_dest_wr;
    logic [pbz_pkg::DepthW-1:0]    r3_new_depth;
    logic                          r3_depth_wr;
    logic                          r3_row_end;

    // stage 1 combinational
    logic                          w1_draw;
    logic                          w1_zwrite;
    logic [pbz_pkg::IdxW-1:0]      w1_pal_idx;
    logic [pbz_pkg::ColorW-1:0]    w1_dhalf;
    logic [pbz_pkg::ColorW-1:0]    w1_dquart;
    logic [pbz_pkg::ColorW-1:0]    n2_dpart;
    logic [pbz_pkg::DepthW-1:0]    n2_depth;

    // stage 2 combinational
    logic [pbz_pkg::ColorW-1:0]    w2_shalf;
    logic [pbz_pkg::ColorW-1:0]    w2_squart;
    logic [pbz_pkg::ColorW-1:0]    w2_blend;
    logic [pbz_pkg::ColorW-1:0]    n3_new_dest;

    // the whole pipe moves unless a held result is stalled
    assign w_advance  = !r_v3 || !i_out_stall;
    assign w_accept   = i_in_valid && w_advance;
    assign o_in_stall = !w_advance;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_translate   <= 1'b0;
            r_blend_mode  <= 3'd0;
            r_transparent <= 1'b0;
            r_depth_test  <= 1'b0;
            r_depth_write <= 1'b0;
            r_depth_byte  <= 1'b0;
            r_z_min       <= '0;
            r_color_mask  <= '0;
        end else if (i_cfg_we) begin
            case (pbz_pkg::t_cfg_reg'(i_cfg_index))
                pbz_pkg::REG_TRANSLATE:   r_translate   <= i_cfg_data[0];
                pbz_pkg::REG_BLEND:       r_blend_mode  <= i_cfg_data[2:0];
                pbz_pkg::REG_TRANSPARENT: r_transparent <= i_cfg_data[0];
                pbz_pkg::REG_DEPTH_TEST:  r_depth_test  <= i_cfg_data[0];
                pbz_pkg::REG_DEPTH_WRITE: r_depth_write <= i_cfg_data[0];
                pbz_pkg::REG_DEPTH_BYTE:  r_depth_byte  <= i_cfg_data[0];
                pbz_pkg::REG_Z_MIN:       r_z_min       <= i_cfg_data;
                pbz_pkg::REG_COLOR_MASK:  r_color_mask  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_advance) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // remap memory: write on accepted load, read for the incoming request
    always_ff @(posedge i_clk) begin
        if (w_accept && i_command == pbz_pkg::CMD_LOAD_REMAP) begin
            r_remap_mem[i_source_index] <= i_table_data[pbz_pkg::RemapW-1:0];
        end
        if (w_advance) begin
            r1_remap_q <= r_remap_mem[i_source_index];
        end
    end

    // capture request into stage 1
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r1_cmd     <= pbz_pkg::t_cmd'(i_command);
            r1_src     <= i_source_index;
            r1_dest    <= i_dest_pixel;
            r1_depth   <= i_depth_value;
            r1_data    <= i_table_data;
            r1_row_end <= i_row_end;
        end
    end

    // stage 1: draw decision, depth value, destination share of the blend
    always_comb begin
        w1_draw = (r1_cmd == pbz_pkg::CMD_PIXEL)
                  && !(r_transparent && r1_src == '0)
                  && !(r_depth_test && !(r_z_min < r1_depth));
        w1_zwrite  = w1_draw && r_depth_test && r_depth_write;
        w1_pal_idx = r_translate ? r1_remap_q[pbz_pkg::IdxW-1:0] : r1_src;
        w1_dhalf   = (r1_dest >> 1) & r_color_mask;
        w1_dquart  = (r1_dest >> 2) & r_color_mask;
        case (pbz_pkg::t_blend'(r_blend_mode))
            pbz_pkg::BLEND_DARKEN:  n2_dpart = w1_dhalf;
            pbz_pkg::BLEND_HALF:    n2_dpart = w1_dhalf;
            pbz_pkg::BLEND_QUARTER: n2_dpart = w1_dquart;
            pbz_pkg::BLEND_THREEQ:  n2_dpart = w1_dquart + (w1_dquart << 1);
            default:                n2_dpart = '0;
        endcase
        if (w1_zwrite) begin
            n2_depth = r_depth_byte ? {8'h00, r_z_min[7:0]} : r_z_min;
        end else begin
            n2_depth = r1_depth;
        end
    end

    // palette memory: write loads and read pixels in request order
    always_ff @(posedge i_clk) begin
        if (w_advance && r_v1 && r1_cmd == pbz_pkg::CMD_LOAD_PALETTE) begin
            r_palette_mem[r1_src] <= r1_data;
        end
        if (w_advance) begin
            r2_pal_q <= r_palette_mem[w1_pal_idx];
        end
    end

    // capture stage 2
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r2_dest    <= r1_dest;
            r2_dpart   <= n2_dpart;
            r2_depth   <= n2_depth;
            r2_draw    <= w1_draw;
            r2_zwrite  <= w1_zwrite;
            r2_row_end <= r1_row_end;
        end
    end

    // stage 2: add source share (none for darken, full palette colour for copy), wrap to 16 bits
    always_comb begin
        w2_shalf  = (r2_pal_q >> 1) & r_color_mask;
        w2_squart = (r2_pal_q >> 2) & r_color_mask;
        case (pbz_pkg::t_blend'(r_blend_mode))
            pbz_pkg::BLEND_DARKEN:  w2_blend = r2_dpart;
            pbz_pkg::BLEND_HALF:    w2_blend = r2_dpart + w2_shalf;
            pbz_pkg::BLEND_QUARTER: w2_blend = r2_dpart + w2_squart + (w2_squart << 1);
            pbz_pkg::BLEND_THREEQ:  w2_blend = r2_dpart + w2_squart;
            default:                w2_blend = r2_pal_q;
        endcase
        n3_new_dest = r2_draw ? w2_blend : r2_dest;
    end

    // hold result in the output register
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r3_new_dest  <= n3_new_dest;
            r3_dest_wr   <= r2_draw;
            r3_new_depth <= r2_depth;
            r3_depth_wr  <= r2_zwrite;
            r3_row_end   <= r2_row_end;
        end
    end

    assign o_out_valid     = r_v3;
    assign o_new_dest      = r3_new_dest;
    assign o_dest_written  = r3_dest_wr;
    assign o_new_depth     = r3_new_depth;
    assign o_depth_written = r3_depth_wr;
    assign o_row_end_out   = r3_row_end;

    // pipeline checks
    `PBZ_ASSERT_NOW(a_stall_only_when_full, o_in_stall, r_v3,
        "input stalled while output register empty")
    `PBZ_ASSERT_NEXT(a_stage2_reaches_out, r_v2 && w_advance, r_v3,
        "stage 2 request lost on advance")
    `PBZ_ASSERT_NOW(a_depth_needs_draw, r_v3 && r3_depth_wr, r3_dest_wr && r_depth_test,
        "depth written without a drawn, depth-tested pixel")
    `PBZ_ASSERT_NEXT(a_hold_on_stall, r_v3 && i_out_stall, r_v3 && $stable(r3_new_dest),
        "output register changed while stalled")

endmodule

>>> sim/palette_blend_ztest_pixel_test.sv
// Testbench for palette_blend_ztest_pixel: table loads, blend modes, transparency and depth test.
// Needs pbz_pkg and the block's RTL; predicts every result and checks it field by field.
`timescale 1ns / 100ps

module palette_blend_ztest_pixel_test;

    typedef struct {
        pbz_pkg::t_cmd cmd;
        logic [7:0]    index;
        logic [15:0]   dest;
        logic [15:0]   depth;
        logic [15:0]   data;
        logic          row_end;
    } t_pixel_request;

    typedef struct {
        logic [15:0] new_dest;
        logic        dest_written;
        logic [15:0] new_depth;
        logic        depth_written;
        logic        row_end_out;
    } t_pixel_result;

    typedef struct {
        logic        translate;
        logic [2:0]  blend;
        logic        transparent;
        logic        depth_test;
        logic        depth_write;
        logic        depth_byte;
        logic [15:0] z_min;
        logic [15:0] color_mask;
    } t_blit_config;

    // DUT ports, inputs all known from time zero
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [pbz_pkg::CfgIdxW-1:0]    i_cfg_index = '0;
    logic [pbz_pkg::CfgDataW-1:0]   i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [1:0]                     i_command = '0;
    logic [pbz_pkg::IdxW-1:0]       i_source_index = '0;
    logic [pbz_pkg::ColorW-1:0]     i_dest_pixel = '0;
    logic [pbz_pkg::DepthW-1:0]     i_depth_value = '0;
    logic [15:0]                    i_table_data = '0;
    logic                           i_row_end = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [pbz_pkg::ColorW-1:0]     o_new_dest;
    logic                           o_dest_written;
    logic [pbz_pkg::DepthW-1:0]     o_new_depth;
    logic                           o_depth_written;
    logic                           o_row_end_out;

    // Shadow of the block's tables and registers
    logic [15:0]   palette_mem [pbz_pkg::TableEntries];
    logic [7:0]    remap_mem [pbz_pkg::TableEntries];
    bit            palette_loaded [pbz_pkg::TableEntries];
    bit            remap_loaded [pbz_pkg::TableEntries];
    t_blit_config  active_cfg;

    t_pixel_result expected_results [$];
    int            mismatch_count = 0;
    bit            idle_enable = 1'b0;
    bit            request_held = 1'b0;
    int            stall_left = 0;

    palette_blend_ztest_pixel DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_source_index  (i_source_index),
        .i_dest_pixel    (i_dest_pixel),
        .i_depth_value   (i_depth_value),
        .i_table_data    (i_table_data),
        .i_row_end       (i_row_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_new_dest      (o_new_dest),
        .o_dest_written  (o_dest_written),
        .o_new_depth     (o_new_depth),
        .o_depth_written (o_depth_written),
        .o_row_end_out   (o_row_end_out)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("palette_blend_ztest_pixel test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [15:0] blend_color(input logic [15:0] d, input logic [15:0] s);
        logic [15:0] half_d;
        logic [15:0] half_s;
        logic [15:0] quarter_d;
        logic [15:0] quarter_s;
        half_d    = (d >> 1) & active_cfg.color_mask;
        half_s    = (s >> 1) & active_cfg.color_mask;
        quarter_d = (d >> 2) & active_cfg.color_mask;
        quarter_s = (s >> 2) & active_cfg.color_mask;
        case (active_cfg.blend)
            pbz_pkg::BLEND_DARKEN:  return half_d;
            pbz_pkg::BLEND_HALF:    return half_d + half_s;
            pbz_pkg::BLEND_QUARTER: return quarter_d + 16'(3 * quarter_s);
            pbz_pkg::BLEND_THREEQ:  return 16'(3 * quarter_d) + quarter_s;
            // undefined modes fall back to copy
            default:                return s;
        endcase
    endfunction

    // Compute the result of one request and apply its table write
    function automatic t_pixel_result blit_pixel(input t_pixel_request req);
        t_pixel_result res;
        logic          draw;
        logic [7:0]    pal_idx;
        res.new_dest      = req.dest;
        res.dest_written  = 1'b0;
        res.new_depth     = req.depth;
        res.depth_written = 1'b0;
        res.row_end_out   = req.row_end;
        case (req.cmd)
            pbz_pkg::CMD_PIXEL: begin
                // transparency looks at the raw index, before remap
                draw = !(active_cfg.transparent && req.index == 8'd0) &&
                       !(active_cfg.depth_test && !(active_cfg.z_min < req.depth));
                if (draw) begin
                    pal_idx = active_cfg.translate ? remap_mem[req.index] : req.index;
                    res.new_dest     = blend_color(req.dest, palette_mem[pal_idx]);
                    res.dest_written = 1'b1;
                    if (active_cfg.depth_test && active_cfg.depth_write) begin
                        res.new_depth = active_cfg.depth_byte ? {8'd0, active_cfg.z_min[7:0]}
                                                              : active_cfg.z_min;
                        res.depth_written = 1'b1;
                    end
                end
            end
            pbz_pkg::CMD_LOAD_PALETTE: begin
                palette_mem[req.index]    = req.data;
                palette_loaded[req.index] = 1'b1;
            end
            pbz_pkg::CMD_LOAD_REMAP: begin
                remap_mem[req.index]    = req.data[7:0];
                remap_loaded[req.index] = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall and check
    // ------------------------------------------------------------------

    function automatic int draw_wait();
        return idle_enable ? $urandom_range(0, 16) : 0;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        t_pixel_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: result with no request pending, actual dest %h depth %h",
                     $time, o_new_dest, o_new_depth);
            mismatch_count++;
        end else begin
            want = expected_results.pop_front();
            compare_field("new_dest", want.new_dest, o_new_dest);
            compare_field("dest_written", {15'd0, want.dest_written}, {15'd0, o_dest_written});
            compare_field("new_depth", want.new_depth, o_new_depth);
            compare_field("depth_written", {15'd0, want.depth_written},
                          {15'd0, o_depth_written});
            compare_field("row_end_out", {15'd0, want.row_end_out}, {15'd0, o_row_end_out});
        end
    endtask

    // Check each accepted result, then hold stall while a random countdown from draw_wait runs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            check_result();
            stall_left = draw_wait();
            i_out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            if (stall_left == 0) begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    task automatic drop_request();
        if (request_held) begin
            i_in_valid <= 1'b0;
            request_held = 1'b0;
        end
    endtask

    task automatic send_request(input t_pixel_request req);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            drop_request();
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= req.cmd;
        i_source_index <= req.index;
        i_dest_pixel   <= req.dest;
        i_depth_value  <= req.depth;
        i_table_data   <= req.data;
        i_row_end      <= req.row_end;
        request_held = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(blit_pixel(req));
    endtask

    task automatic send_command(input pbz_pkg::t_cmd cmd, input logic [7:0] index,
                                input logic [15:0] dest, input logic [15:0] depth,
                                input logic [15:0] data);
        t_pixel_request req;
        req.cmd     = cmd;
        req.index   = index;
        req.dest    = dest;
        req.depth   = depth;
        req.data    = data;
        req.row_end = 1'($urandom);
        send_request(req);
    endtask

    // Pause until every pending result has come back
    task automatic wait_drained();
        drop_request();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_registers(input t_blit_config cfg);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pbz_pkg::REG_TRANSLATE;
        i_cfg_data  <= {15'd0, cfg.translate};
        @(posedge i_clk);
        i_cfg_index <= pbz_pkg::REG_BLEND;
        i_cfg_data  <= {13'd0, cfg.blend};
        @(posedge i_clk);
        i_cfg_index <= pbz_pkg::REG_TRANSPARENT;
        i_cfg_data  <= {15'd0, cfg.transparent};
        @(posedge i_clk);
        i_cfg_index <= pbz_pkg::REG_DEPTH_TEST;
        i_cfg_data  <= {15'd0, cfg.depth_test};
        @(posedge i_clk);
        i_cfg_index <= pbz_pkg::REG_DEPTH_WRITE;
        i_cfg_data  <= {15'd0, cfg.depth_write};
        @(posedge i_clk);
        i_cfg_index <= pbz_pkg::REG_DEPTH_BYTE;
        i_cfg_data  <= {15'd0, cfg.depth_byte};
        @(posedge i_clk);
        i_cfg_index <= pbz_pkg::REG_Z_MIN;
        i_cfg_data  <= cfg.z_min;
        @(posedge i_clk);
        i_cfg_index <= pbz_pkg::REG_COLOR_MASK;
        i_cfg_data  <= cfg.color_mask;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        active_cfg = cfg;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // An index is usable only if every table entry it reads has been loaded
    function automatic bit entry_ready(input logic [7:0] c, input logic via_remap);
        if (via_remap) begin
            return remap_loaded[c] && palette_loaded[remap_mem[c]];
        end
        return palette_loaded[c];
    endfunction

    function automatic logic [7:0] pick_ready_index(input logic via_remap);
        logic [7:0] c;
        for (int n = 0; n < 4; n++) begin
            c = 8'($urandom);
            if (entry_ready(c, via_remap)) return c;
        end
        for (int n = 0; n < pbz_pkg::TableEntries; n++) begin
            c = c + 8'd1;
            if (entry_ready(c, via_remap)) return c;
        end
        return c;
    endfunction

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Bias depth around z_min to hit both sides of the compare
    function automatic logic [15:0] random_depth();
        case ($urandom_range(0, 7))
            0:       return active_cfg.z_min;
            1:       return active_cfg.z_min + 16'd1;
            2:       return active_cfg.z_min - 16'd1;
            3:       return 16'h0000;
            4:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_blit_config random_config();
        t_blit_config cfg;
        cfg.translate   = 1'($urandom);
        cfg.blend       = 3'($urandom);
        cfg.transparent = 1'($urandom);
        cfg.depth_test  = 1'($urandom);
        cfg.depth_write = 1'($urandom);
        cfg.depth_byte  = 1'($urandom);
        cfg.z_min       = random_word();
        cfg.color_mask  = random_word();
        return cfg;
    endfunction

    task automatic send_random_request();
        t_pixel_request req;
        int             pick;
        pick        = $urandom_range(0, 99);
        req.index   = 8'($urandom);
        req.dest    = random_word();
        req.depth   = random_depth();
        req.data    = 16'($urandom);
        req.row_end = 1'($urandom);
        if (pick < 70) begin
            req.cmd = pbz_pkg::CMD_PIXEL;
            if ($urandom_range(0, 15) == 0 && entry_ready(8'd0, active_cfg.translate)) begin
                req.index = 8'd0;
            end else begin
                req.index = pick_ready_index(active_cfg.translate);
            end
        end else if (pick < 82) begin
            req.cmd = pbz_pkg::CMD_LOAD_PALETTE;
        end else if (pick < 94) begin
            req.cmd = pbz_pkg::CMD_LOAD_REMAP;
            // mostly point the remap at a loaded palette entry
            if ($urandom_range(0, 3) != 0) begin
                req.data[7:0] = pick_ready_index(1'b0);
            end
        end else begin
            req.cmd = pbz_pkg::CMD_RESERVED;
        end
        send_request(req);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_table_loads();
        t_blit_config cfg;
        cfg = '{default: '0};
        program_registers(cfg);
        send_command(pbz_pkg::CMD_LOAD_PALETTE, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_command(pbz_pkg::CMD_LOAD_PALETTE, 8'hFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_command(pbz_pkg::CMD_LOAD_PALETTE, 8'h55, 16'h1234, 16'h4321, 16'hAAAA);
        send_command(pbz_pkg::CMD_LOAD_PALETTE, 8'hAA, 16'h8000, 16'h0001, 16'h5555);
        send_command(pbz_pkg::CMD_LOAD_REMAP, 8'h00, 16'h0000, 16'h0000, 16'hA5FF);
        send_command(pbz_pkg::CMD_LOAD_REMAP, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFF00);
        send_command(pbz_pkg::CMD_LOAD_REMAP, 8'h05, 16'h0F0F, 16'hF0F0, 16'h1200);
        send_command(pbz_pkg::CMD_LOAD_REMAP, 8'h55, 16'h00FF, 16'hFF00, 16'h34AA);
        send_command(pbz_pkg::CMD_PIXEL, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    endtask

    task automatic test_blend_modes();
        t_blit_config cfg;
        cfg = '{default: '0};
        cfg.color_mask = 16'hFFFF;
        // sweep every mode, including the undefined ones
        for (int b = 0; b < 8; b++) begin
            cfg.blend = 3'(b);
            program_registers(cfg);
            send_command(pbz_pkg::CMD_PIXEL, 8'h55, 16'hFFFF, 16'h0000, 16'h0000);
        end
    endtask

    task automatic test_transparency();
        t_blit_config cfg;
        cfg = '{default: '0};
        cfg.translate   = 1'b1;
        cfg.transparent = 1'b1;
        program_registers(cfg);
        send_command(pbz_pkg::CMD_PIXEL, 8'h00, 16'h1357, 16'h2468, 16'h0000);
        send_command(pbz_pkg::CMD_PIXEL, 8'h05, 16'h1357, 16'h2468, 16'h0000);
        cfg.translate = 1'b0;
        program_registers(cfg);
        send_command(pbz_pkg::CMD_PIXEL, 8'h00, 16'hBEEF, 16'h0000, 16'h0000);
    endtask

    task automatic test_depth();
        t_blit_config cfg;
        cfg = '{default: '0};
        cfg.depth_test  = 1'b1;
        cfg.depth_write = 1'b1;
        cfg.depth_byte  = 1'b1;
        cfg.z_min       = 16'h1234;
        program_registers(cfg);
        send_command(pbz_pkg::CMD_PIXEL, 8'hAA, 16'h0000, 16'h1234, 16'h0000);
        send_command(pbz_pkg::CMD_PIXEL, 8'hAA, 16'h0000, 16'h1235, 16'h0000);
        cfg.depth_byte = 1'b0;
        cfg.z_min      = 16'hFFFF;
        program_registers(cfg);
        send_command(pbz_pkg::CMD_PIXEL, 8'hAA, 16'h0000, 16'hFFFF, 16'h0000);
        cfg.z_min = 16'h0000;
        program_registers(cfg);
        send_command(pbz_pkg::CMD_PIXEL, 8'h00, 16'h0000, 16'h0001, 16'h0000);
        // depth write with the test off writes nothing
        cfg.depth_test = 1'b0;
        program_registers(cfg);
        send_command(pbz_pkg::CMD_PIXEL, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_reserved_command();
        send_command(pbz_pkg::CMD_RESERVED, 8'h55, 16'hCAFE, 16'h7777, 16'h0000);
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 10; phase++) begin
            program_registers(random_config());
            idle_enable = (phase % 3 != 1);
            for (int n = 0; n < 170; n++) begin
                // hold off the sender until everything drains
                if (phase % 2 == 0 && n == 85) begin
                    wait_drained();
                end
                send_random_request();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        active_cfg = '{default: '0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_loads();
        test_blend_modes();
        test_transparency();
        test_depth();
        test_reserved_command();
        test_random_stream();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("palette_blend_ztest_pixel test passed");
        end else begin
            $display("palette_blend_ztest_pixel test failed");
        end
        $finish;
    end

endmodule
